// File: src/trmce_pkg.sv
package trmce_pkg;

   // Default number of words in the data memory.
   localparam int unsigned MEM_DEPTH_DEFAULT = 65536;

   // Register file size and value width.
   localparam int unsigned NUM_REGS   = 4;
   localparam int unsigned WORD_WIDTH = 32;

   // Opcodes. Any other code is an unknown opcode.
   localparam logic [2:0] ACT_MOV = 3'd0;
   localparam logic [2:0] ACT_ADD = 3'd1;
   localparam logic [2:0] ACT_SUB = 3'd2;
   localparam logic [2:0] ACT_MUL = 3'd3;
   localparam logic [2:0] ACT_HLT = 3'd4;

   // Operand kinds. Any kind other than register or memory is an immediate.
   localparam logic [1:0] KIND_REG = 2'd0;
   localparam logic [1:0] KIND_MEM = 2'd1;
   localparam logic [1:0] KIND_IMM = 2'd2;

   // Register index of the accumulator.
   localparam logic [1:0] REG_AX = 2'd0;

   // Result status codes.
   localparam logic [2:0] STS_OK          = 3'd0;
   localparam logic [2:0] STS_HALT        = 3'd1;
   localparam logic [2:0] STS_BAD_OPCODE  = 3'd2;
   localparam logic [2:0] STS_BAD_DEST    = 3'd3;
   localparam logic [2:0] STS_BAD_ADDRESS = 3'd4;
   localparam logic [2:0] STS_IGNORED     = 3'd5;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ_B,
      ST_EXEC
   } trmce_state_type;

endpackage

// File: src/tiny_register_memory_cpu_executor.sv
// Executes one decoded two-operand instruction per transaction on four
// 32-bit registers (AX, BX, CX, DX) and a word memory of MEM_DEPTH entries.
// After reset the block first clears the memory, one word per cycle, and
// holds req_ready low until the clearing pass ends. Each instruction then
// passes the READ_B and EXEC states: the memory has a single read port,
// and an instruction may need two memory operands, read in consecutive
// cycles. Its result is loaded into the output register as EXEC ends, which
// waits for a free output register, and the next request is accepted in
// that same cycle. The rsp_*x_value ports show the registers after the
// instruction that is being reported.
module tiny_register_memory_cpu_executor #(
   parameter int unsigned MEM_DEPTH = trmce_pkg::MEM_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_action,
   input  logic [1:0]         req_a_kind,
   input  logic [1:0]         req_a_reg,
   input  logic signed [31:0] req_a_number,
   input  logic [1:0]         req_b_kind,
   input  logic [1:0]         req_b_reg,
   input  logic signed [31:0] req_b_number,

   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_written_value,
   output logic signed [31:0] rsp_ax_value,
   output logic signed [31:0] rsp_bx_value,
   output logic signed [31:0] rsp_cx_value,
   output logic signed [31:0] rsp_dx_value
);

   import trmce_pkg::*;

   localparam int unsigned AW = $clog2(MEM_DEPTH);

   // Sequencer and control state.
   trmce_state_type state_ff, state_in;
   logic [AW-1:0]   clr_cnt_ff, clr_cnt_in;
   logic            halted_ff, halted_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // Instruction held from acceptance to execution.
   logic [2:0]  act_ff;
   logic [1:0]  a_kind_ff, a_reg_ff, b_kind_ff, b_reg_ff;
   logic [31:0] a_num_ff, b_num_ff;
   logic        a_ok_ff, b_ok_ff;

   // Register file and captured memory operand A.
   logic [31:0] regs_ff [NUM_REGS];
   logic [31:0] a_mem_ff;

   // Forwarding of a write that hit the address read in the same cycle.
   logic        fwd_hit_ff, fwd_hit_in;
   logic [31:0] fwd_data_ff;

   // Result registers.
   logic [2:0]  status_ff, status_in;
   logic [31:0] written_ff, written_in;

   // Memory port signals.
   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [31:0]   ram_wdata, ram_rdata, mem_rd;

   // Handshake and execute signals.
   logic        out_free, ex_fire, req_fire;
   logic        req_a_ok, req_b_ok, clr_last;
   logic [31:0] va, vb, sum, diff, prod, alu_res;
   logic        reg_we, mem_we_ex;
   logic [1:0]  reg_idx;
   logic [31:0] reg_data;

   trmce_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (MEM_DEPTH)
   ) u_data_mem (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Address range checks on the incoming transaction.
   assign req_a_ok = $unsigned(req_a_number) < 32'(MEM_DEPTH);
   assign req_b_ok = $unsigned(req_b_number) < 32'(MEM_DEPTH);
   assign clr_last = clr_cnt_ff == AW'(MEM_DEPTH - 1);

   // Handshake: the output register takes a result when empty or drained.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign ex_fire   = (state_ff == ST_EXEC) && out_free;
   assign req_ready = (state_ff == ST_IDLE) || ex_fire;
   assign req_fire  = req_valid && req_ready;

   // Memory read data with the same-cycle write folded in.
   assign mem_rd = fwd_hit_ff ? fwd_data_ff : ram_rdata;

   // Operand values.
   always_comb begin
      unique case (a_kind_ff)
         KIND_REG: va = regs_ff[a_reg_ff];
         KIND_MEM: va = a_mem_ff;
         default:  va = a_num_ff;
      endcase
      unique case (b_kind_ff)
         KIND_REG: vb = regs_ff[b_reg_ff];
         KIND_MEM: vb = mem_rd;
         default:  vb = b_num_ff;
      endcase
   end

   // Arithmetic, wrapping to 32 bits.
   assign sum  = va + vb;
   assign diff = va - vb;
   assign prod = va * vb;

   always_comb begin
      unique case (act_ff)
         ACT_ADD: alu_res = sum;
         ACT_SUB: alu_res = diff;
         default: alu_res = prod;
      endcase
   end

   // Status, written value and the register or memory write of the
   // instruction in execution.
   always_comb begin
      status_in  = STS_OK;
      written_in = '0;
      reg_we     = 1'b0;
      reg_idx    = REG_AX;
      reg_data   = vb;
      mem_we_ex  = 1'b0;
      halted_in  = halted_ff;
      priority if (halted_ff) begin
         status_in = STS_IGNORED;
      end else if (act_ff == ACT_HLT) begin
         status_in = STS_HALT;
         halted_in = ex_fire;
      end else if (act_ff == ACT_MOV) begin
         priority if (b_kind_ff == KIND_MEM && !b_ok_ff) begin
            status_in = STS_BAD_ADDRESS;
         end else if (a_kind_ff == KIND_REG) begin
            reg_we     = ex_fire;
            reg_idx    = a_reg_ff;
            written_in = vb;
         end else if (a_kind_ff == KIND_MEM) begin
            if (a_ok_ff) begin
               mem_we_ex  = ex_fire;
               written_in = vb;
            end else begin
               status_in = STS_BAD_ADDRESS;
            end
         end else begin
            status_in = STS_BAD_DEST;
         end
      end else if (act_ff == ACT_ADD || act_ff == ACT_SUB || act_ff == ACT_MUL) begin
         if ((a_kind_ff == KIND_MEM && !a_ok_ff) || (b_kind_ff == KIND_MEM && !b_ok_ff)) begin
            status_in = STS_BAD_ADDRESS;
         end else begin
            reg_we     = ex_fire;
            reg_data   = alu_res;
            written_in = alu_res;
         end
      end else begin
         status_in = STS_BAD_OPCODE;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_READ_B;
            end
         end
         ST_READ_B: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (ex_fire) begin
               state_in = req_fire ? ST_READ_B : ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Memory port control: clearing pass, operand reads and the MOV write.
   always_comb begin
      ram_we     = 1'b0;
      ram_waddr  = a_num_ff[AW-1:0];
      ram_wdata  = vb;
      ram_re     = 1'b0;
      ram_raddr  = b_num_ff[AW-1:0];
      clr_cnt_in = clr_cnt_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we     = 1'b1;
            ram_waddr  = clr_cnt_ff;
            ram_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + AW'(1);
         end
         ST_READ_B: begin
            ram_re = (b_kind_ff == KIND_MEM) && b_ok_ff;
         end
         ST_IDLE, ST_EXEC: begin
            ram_we = mem_we_ex;
            if (req_fire) begin
               ram_raddr = req_a_number[AW-1:0];
               ram_re    = (req_a_kind == KIND_MEM) && req_a_ok;
            end
         end
         default: ;
      endcase
      fwd_hit_in   = ram_we && (ram_waddr == ram_raddr);
      rsp_valid_in = ex_fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_hit_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ram_re) begin
            fwd_hit_ff <= fwd_hit_in;
         end
      end
   end

   // Register file, cleared at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= '0;
         end
      end else if (reg_we) begin
         regs_ff[reg_idx] <= reg_data;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         act_ff    <= req_action;
         a_kind_ff <= req_a_kind;
         a_reg_ff  <= req_a_reg;
         a_num_ff  <= req_a_number;
         a_ok_ff   <= req_a_ok;
         b_kind_ff <= req_b_kind;
         b_reg_ff  <= req_b_reg;
         b_num_ff  <= req_b_number;
         b_ok_ff   <= req_b_ok;
      end
      if (state_ff == ST_READ_B) begin
         a_mem_ff <= mem_rd;
      end
      if (ram_re) begin
         fwd_data_ff <= ram_wdata;
      end
      if (ex_fire) begin
         status_ff  <= status_in;
         written_ff <= written_in;
      end
   end

   // The register outputs change only when a new result is loaded, which
   // happens only once the previous result has been taken.
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_written_value = written_ff;
   assign rsp_ax_value      = regs_ff[0];
   assign rsp_bx_value      = regs_ff[1];
   assign rsp_cx_value      = regs_ff[2];
   assign rsp_dx_value      = regs_ff[3];

   // An accepted transaction always moves on to the second operand read.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_READ_B)
      else $error("accepted transaction did not enter the operand read");

   // The halt flag never clears outside reset.
   assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt flag cleared without reset");

   // Once halted, the memory is never written again.
   assert property (@(posedge clock) disable iff (reset)
      halted_ff && state_ff != ST_CLEAR |-> !ram_we)
      else $error("memory written after halt");

   // A completed instruction shows up as a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      ex_fire |=> rsp_valid_ff)
      else $error("executed instruction produced no result");

   // Error results never carry a written value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != STS_OK |-> written_ff == '0)
      else $error("written value nonzero on an error result");

endmodule

// File: src/trmce_ram.sv
module trmce_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port; a read of the address
   // written in the same cycle returns the old word.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: test/tiny_register_memory_cpu_executor_tb.sv
`timescale 1ns / 1ps

module tiny_register_memory_cpu_executor_tb;
   import trmce_pkg::*;

   localparam int unsigned MEM_WORDS = MEM_DEPTH_DEFAULT;
   // The clearing pass after reset accepts nothing until every memory word is cleared.
   localparam int unsigned WATCHDOG_LIMIT = 4 * MEM_WORDS;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned CHUNK_ITEMS = 100;
   localparam int unsigned CHUNK_COUNT = 14;

   // Register indexes beyond AX.
   localparam logic [1:0] REG_BX = 2'd1;
   localparam logic [1:0] REG_CX = 2'd2;
   localparam logic [1:0] REG_DX = 2'd3;

   // Unused opcodes and the spare operand kind, which acts as an immediate.
   localparam logic [2:0] ACT_UNUSED_5 = 3'd5;
   localparam logic [2:0] ACT_UNUSED_6 = 3'd6;
   localparam logic [2:0] ACT_UNUSED_7 = 3'd7;
   localparam logic [1:0] KIND_SPARE = 2'd3;

   typedef struct packed {
      logic [2:0]  action;
      logic [1:0]  a_kind;
      logic [1:0]  a_reg;
      logic [31:0] a_number;
      logic [1:0]  b_kind;
      logic [1:0]  b_reg;
      logic [31:0] b_number;
   } instr_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] written;
      logic [31:0] ax;
      logic [31:0] bx;
      logic [31:0] cx;
      logic [31:0] dx;
   } result_type;

   typedef enum logic [1:0] {
      RX_STEADY,
      RX_CHOPPY,
      RX_SLOW
   } rx_mode_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [2:0]         req_action = '0;
   logic [1:0]         req_a_kind = '0;
   logic [1:0]         req_a_reg = '0;
   logic signed [31:0] req_a_number = '0;
   logic [1:0]         req_b_kind = '0;
   logic [1:0]         req_b_reg = '0;
   logic signed [31:0] req_b_number = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [2:0]         rsp_status;
   logic signed [31:0] rsp_written_value;
   logic signed [31:0] rsp_ax_value;
   logic signed [31:0] rsp_bx_value;
   logic signed [31:0] rsp_cx_value;
   logic signed [31:0] rsp_dx_value;

   // Machine state mirrored by the predictor.
   logic [31:0] reg_file [NUM_REGS];
   logic [31:0] data_mem [MEM_WORDS];
   logic        halted = 1'b0;

   instr_type   instr_queue[$];
   result_type  expected_results[$];
   instr_type   current_instr;
   result_type  expected_result;
   int unsigned error_count = 0;
   int unsigned idle_cycles = 0;
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;
   int unsigned hold_requests = 0;
   int unsigned holds_served = 0;
   int unsigned hold_left = 0;
   int unsigned rx_span = 0;
   rx_mode_type rx_mode = RX_STEADY;

   tiny_register_memory_cpu_executor #(
      .MEM_DEPTH(MEM_WORDS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_action(req_action),
      .req_a_kind(req_a_kind),
      .req_a_reg(req_a_reg),
      .req_a_number(req_a_number),
      .req_b_kind(req_b_kind),
      .req_b_reg(req_b_reg),
      .req_b_number(req_b_number),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_written_value(rsp_written_value),
      .rsp_ax_value(rsp_ax_value),
      .rsp_bx_value(rsp_bx_value),
      .rsp_cx_value(rsp_cx_value),
      .rsp_dx_value(rsp_dx_value)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // Appends one instruction to the pending stimulus.
   function automatic void enqueue_instr(input instr_type ins);
      instr_queue.insert(instr_queue.size(), ins);
   endfunction

   // Appends one predicted result to the scoreboard.
   function automatic void enqueue_result(input result_type res);
      expected_results.insert(expected_results.size(), res);
   endfunction

   // Reads one operand; returns zero when a memory address is out of range.
   function automatic logic fetch_operand(input logic [1:0] kind, input logic [1:0] reg_index,
                                          input logic [31:0] number, output logic [31:0] value);
      value = number;
      if (kind == KIND_REG) begin
         value = reg_file[reg_index];
      end else if (kind == KIND_MEM) begin
         if (number >= MEM_WORDS) return 1'b0;
         value = data_mem[number];
      end
      return 1'b1;
   endfunction

   // Executes one instruction on the mirrored state and returns its result.
   function automatic result_type execute_instruction(input instr_type ins);
      result_type  res;
      logic [31:0] va;
      logic [31:0] vb;
      logic        ok_a;
      logic        ok_b;
      res = '0;
      va = '0;
      vb = '0;
      if (halted) begin
         res.status = STS_IGNORED;
      end else begin
         case (ins.action)
            ACT_HLT: begin
               halted = 1'b1;
               res.status = STS_HALT;
            end
            ACT_MOV: begin
               // The source is checked before the destination.
               if (!fetch_operand(ins.b_kind, ins.b_reg, ins.b_number, vb)) begin
                  res.status = STS_BAD_ADDRESS;
               end else if (ins.a_kind == KIND_REG) begin
                  reg_file[ins.a_reg] = vb;
                  res.written = vb;
               end else if (ins.a_kind == KIND_MEM) begin
                  if (ins.a_number >= MEM_WORDS) begin
                     res.status = STS_BAD_ADDRESS;
                  end else begin
                     data_mem[ins.a_number] = vb;
                     res.written = vb;
                  end
               end else begin
                  res.status = STS_BAD_DEST;
               end
            end
            ACT_ADD, ACT_SUB, ACT_MUL: begin
               ok_a = fetch_operand(ins.a_kind, ins.a_reg, ins.a_number, va);
               ok_b = fetch_operand(ins.b_kind, ins.b_reg, ins.b_number, vb);
               if (!ok_a || !ok_b) begin
                  res.status = STS_BAD_ADDRESS;
               end else begin
                  if (ins.action == ACT_ADD) res.written = va + vb;
                  else if (ins.action == ACT_SUB) res.written = va - vb;
                  else res.written = va * vb;
                  reg_file[REG_AX] = res.written;
               end
            end
            default: begin
               res.status = STS_BAD_OPCODE;
            end
         endcase
      end
      res.ax = reg_file[REG_AX];
      res.bx = reg_file[REG_BX];
      res.cx = reg_file[REG_CX];
      res.dx = reg_file[REG_DX];
      return res;
   endfunction

   function automatic instr_type make_instr(input logic [2:0] action,
                                            input logic [1:0] a_kind, input logic [1:0] a_reg,
                                            input logic [31:0] a_number,
                                            input logic [1:0] b_kind, input logic [1:0] b_reg,
                                            input logic [31:0] b_number);
      instr_type ins;
      ins.action = action;
      ins.a_kind = a_kind;
      ins.a_reg = a_reg;
      ins.a_number = a_number;
      ins.b_kind = b_kind;
      ins.b_reg = b_reg;
      ins.b_number = b_number;
      return ins;
   endfunction

   // Data values lean toward the arithmetic extremes.
   function automatic logic [31:0] random_value();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   // Addresses mostly hit a few words at both ends so that writes get read back.
   function automatic logic [31:0] random_address();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return $urandom_range(0, 15);
      if (pick < 80) return MEM_WORDS - 1 - $urandom_range(0, 15);
      case ($urandom_range(0, 3))
         0: return MEM_WORDS;
         1: return 32'hFFFF_FFFF;
         2: return $urandom | 32'h8000_0000;
         default: return $urandom | MEM_WORDS;
      endcase
   endfunction

   function automatic void random_operand(output logic [1:0] kind, output logic [1:0] reg_index,
                                          output logic [31:0] number);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) kind = KIND_REG;
      else if (pick < 75) kind = KIND_MEM;
      else if (pick < 95) kind = KIND_IMM;
      else kind = KIND_SPARE;
      reg_index = 2'($urandom_range(0, 3));
      number = (kind == KIND_MEM) ? random_address() : random_value();
   endfunction

   // Random instructions never halt; the halt is kept for the very end.
   function automatic instr_type random_instr();
      instr_type   ins;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 35) ins.action = ACT_MOV;
      else if (pick < 55) ins.action = ACT_ADD;
      else if (pick < 75) ins.action = ACT_SUB;
      else if (pick < 95) ins.action = ACT_MUL;
      else ins.action = 3'($urandom_range(ACT_UNUSED_5, ACT_UNUSED_7));
      random_operand(ins.a_kind, ins.a_reg, ins.a_number);
      random_operand(ins.b_kind, ins.b_reg, ins.b_number);
      return ins;
   endfunction

   // Sampled on the falling edge to stay clear of the driver's updates.
   task automatic wait_for_drain();
      while (instr_queue.size() != 0 || req_valid || expected_results.size() != 0)
         @(negedge clock);
   endtask

   task automatic check_field(input string field, input logic [31:0] exp_value,
                              input logic [31:0] act_value);
      if (exp_value !== act_value) begin
         $error("%s mismatch: expected %0d, actual %0d", field, $signed(exp_value),
                $signed(act_value));
         error_count++;
      end
   endtask

   // Driver: presents queued instructions in bursts separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            enqueue_result(execute_instruction(current_instr));
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (instr_queue.size() != 0) begin
               current_instr = instr_queue.pop_front();
               req_action <= current_instr.action;
               req_a_kind <= current_instr.a_kind;
               req_a_reg <= current_instr.a_reg;
               req_a_number <= current_instr.a_number;
               req_b_kind <= current_instr.b_kind;
               req_b_reg <= current_instr.b_reg;
               req_b_number <= current_instr.b_number;
               req_valid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: switches between stall patterns, and holds off entirely on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (holds_served != hold_requests) begin
         holds_served++;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         if (rx_span == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 2));
            rx_span = $urandom_range(8, 60);
         end else begin
            rx_span--;
         end
         case (rx_mode)
            RX_STEADY: rsp_ready <= 1'b1;
            RX_CHOPPY: rsp_ready <= 1'($urandom_range(0, 1));
            default:   rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Monitor: compares each result transaction with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("Result transaction arrived with no instruction outstanding.");
            error_count++;
         end else begin
            expected_result = expected_results.pop_front();
            check_field("status", expected_result.status, rsp_status);
            check_field("written_value", expected_result.written, rsp_written_value);
            check_field("ax_value", expected_result.ax, rsp_ax_value);
            check_field("bx_value", expected_result.bx, rsp_bx_value);
            check_field("cx_value", expected_result.cx, rsp_cx_value);
            check_field("dx_value", expected_result.dx, rsp_dx_value);
         end
      end
   end

   // Watchdog: ends the run when no transaction moves for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Stimulus: directed corner cases, random chunks, then the halt sequence.
   initial begin
      for (int i = 0; i < NUM_REGS; i++) reg_file[i] = '0;
      for (int i = 0; i < MEM_WORDS; i++) data_mem[i] = '0;

      // Register loads with the value extremes, including the spare immediate kind.
      enqueue_instr(make_instr(ACT_MOV, KIND_REG, REG_AX, 0, KIND_IMM, 0, 32'h7FFF_FFFF));
      enqueue_instr(make_instr(ACT_MOV, KIND_REG, REG_BX, 0, KIND_IMM, 0, 32'h8000_0000));
      enqueue_instr(make_instr(ACT_MOV, KIND_REG, REG_CX, 0, KIND_SPARE, 0, 32'hFFFF_FFFF));
      enqueue_instr(make_instr(ACT_MOV, KIND_REG, REG_DX, 0, KIND_IMM, 0, 32'h5A5A_A5A5));
      // Memory at both ends of the address range.
      enqueue_instr(make_instr(ACT_MOV, KIND_MEM, 0, 0, KIND_REG, REG_BX, 0));
      enqueue_instr(make_instr(ACT_MOV, KIND_MEM, 0, MEM_WORDS - 1, KIND_REG, REG_AX, 0));
      enqueue_instr(make_instr(ACT_MOV, KIND_REG, REG_CX, 0, KIND_MEM, 0, MEM_WORDS - 1));
      // Arithmetic with wraparound and with two memory operands.
      enqueue_instr(make_instr(ACT_ADD, KIND_REG, REG_AX, 0, KIND_MEM, 0, 0));
      enqueue_instr(make_instr(ACT_SUB, KIND_REG, REG_BX, 0, KIND_IMM, 0, 1));
      enqueue_instr(make_instr(ACT_MUL, KIND_REG, REG_CX, 0, KIND_IMM, 0, 32'h7FFF_FFFF));
      enqueue_instr(make_instr(ACT_MUL, KIND_MEM, 0, 0, KIND_MEM, 0, MEM_WORDS - 1));
      enqueue_instr(make_instr(ACT_ADD, KIND_IMM, 0, 32'h8000_0000, KIND_SPARE, 0,
                               32'h8000_0000));
      enqueue_instr(make_instr(ACT_MUL, KIND_REG, REG_DX, 0, KIND_MEM, 0, 1));
      // Destination errors, and the source address checked before the destination.
      enqueue_instr(make_instr(ACT_MOV, KIND_IMM, 0, 7, KIND_REG, REG_AX, 0));
      enqueue_instr(make_instr(ACT_MOV, KIND_MEM, 0, MEM_WORDS, KIND_REG, REG_AX, 0));
      enqueue_instr(make_instr(ACT_MOV, KIND_MEM, 0, 32'hFFFF_FFFF, KIND_REG, REG_AX, 0));
      enqueue_instr(make_instr(ACT_MOV, KIND_REG, REG_AX, 0, KIND_MEM, 0, 32'h8000_0000));
      enqueue_instr(make_instr(ACT_MOV, KIND_IMM, 0, 0, KIND_MEM, 0, MEM_WORDS));
      // Arithmetic with an out-of-range address in either operand leaves AX alone.
      enqueue_instr(make_instr(ACT_ADD, KIND_MEM, 0, MEM_WORDS, KIND_IMM, 0, 5));
      enqueue_instr(make_instr(ACT_SUB, KIND_REG, REG_AX, 0, KIND_MEM, 0, 32'hFFFF_FFFF));
      // Unused opcodes.
      enqueue_instr(make_instr(ACT_UNUSED_5, KIND_REG, REG_AX, 0, KIND_IMM, 0, 1));
      enqueue_instr(make_instr(ACT_UNUSED_6, KIND_MEM, REG_BX, 2, KIND_REG, REG_CX, 0));
      enqueue_instr(make_instr(ACT_UNUSED_7, KIND_IMM, REG_DX, 3, KIND_MEM, 0, 4));
      wait_for_drain();

      // Random chunks; one chunk starts a long receiver hold, another waits for a drain.
      for (int chunk = 0; chunk < CHUNK_COUNT; chunk++) begin
         while (instr_queue.size() >= 20) @(negedge clock);
         if (chunk == 3) hold_requests++;
         if (chunk == 8) wait_for_drain();
         for (int k = 0; k < CHUNK_ITEMS; k++) enqueue_instr(random_instr());
      end
      wait_for_drain();

      // Halt, then everything afterwards is ignored, another halt included.
      enqueue_instr(make_instr(ACT_HLT, KIND_IMM, REG_DX, $urandom, KIND_MEM, 0, MEM_WORDS));
      enqueue_instr(make_instr(ACT_MOV, KIND_REG, REG_BX, 0, KIND_IMM, 0, 9));
      enqueue_instr(make_instr(ACT_HLT, KIND_REG, REG_AX, 0, KIND_REG, REG_AX, 0));
      enqueue_instr(make_instr(ACT_MUL, KIND_MEM, 0, MEM_WORDS, KIND_IMM, 0, 3));
      enqueue_instr(make_instr(ACT_UNUSED_6, KIND_REG, REG_CX, 0, KIND_REG, REG_DX, 0));
      wait_for_drain();
      repeat (10) @(posedge clock);

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: tiny_register_memory_cpu_executor.f
src/trmce_pkg.sv
src/trmce_ram.sv
src/tiny_register_memory_cpu_executor.sv
test/tiny_register_memory_cpu_executor_tb.sv
